// ===== design/kabf_pkg.sv =====
// Package: shared types and constants for the angle/bias Kalman filter core.
`default_nettype none
package kabf_pkg;

    localparam int unsigned CfgIdxW = 2;
    localparam logic [CfgIdxW-1:0] CFG_Q_ANGLE = 2'd0;
    localparam logic [CfgIdxW-1:0] CFG_Q_BIAS  = 2'd1;
    localparam logic [CfgIdxW-1:0] CFG_R_MEAS  = 2'd2;

    localparam logic [30:0] RST_Q_ANGLE = 31'd268435;
    localparam logic [30:0] RST_Q_BIAS  = 31'd805306;
    localparam logic [30:0] RST_R_MEAS  = 31'd8053063;

    localparam logic OP_UPDATE = 1'b0;
    localparam logic OP_FORCE  = 1'b1;

    // datapath micro-operations
    typedef enum logic [4:0] {
        UOP_NONE  = 5'd0,
        UOP_LOAD  = 5'd1,   // latch item, rate = sat(rate - bias)
        UOP_ANG   = 5'd2,   // angle += dt*rate
        UOP_DP11  = 5'd3,   // dp11 = dt*p11
        UOP_INNER = 5'd4,
        UOP_P00   = 5'd5,
        UOP_P11   = 5'd6,   // also p01, p10
        UOP_DIVS  = 5'd7,   // start k0 division, form y
        UOP_DIVK0 = 5'd8,   // capture k0, start k1
        UOP_DIVK1 = 5'd9,
        UOP_CA    = 5'd10,  // angle += k0*y
        UOP_CB    = 5'd11,
        UOP_C00   = 5'd12,
        UOP_C01   = 5'd13,
        UOP_C10   = 5'd14,
        UOP_C11   = 5'd15,
        UOP_FORCE = 5'd16
    } t_uop;

    typedef struct packed {
        t_uop uop;
    } t_cmd;

    typedef struct packed {
        logic div_busy;
    } t_status;

    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        if (v > 66'sd2147483647) return 32'sh7fffffff;
        if (v < -66'sd2147483648) return 32'sh80000000;
        return v[31:0];
    endfunction

    // round half up then arithmetic shift (floor of v+half)
    function automatic logic signed [65:0] rsh16(input logic signed [65:0] v);
        logic signed [65:0] w;
        w = v + 66'sd32768;
        return w >>> 16;
    endfunction

    function automatic logic signed [65:0] rsh28(input logic signed [65:0] v);
        logic signed [65:0] w;
        w = v + 66'sd134217728;
        return w >>> 28;
    endfunction

endpackage
`default_nettype wire

// ===== design/kalman_angle_bias_filter_core.sv =====
// Top level: two-state angle and gyro-bias Kalman filter core.
//
// Input channel (i_in_valid/o_in_ready) takes one beat per item: op,
// measured angle, measured rate (Q16.16) and elapsed time (Q0.16).
// Output channel (o_out_valid/i_out_ready) returns one beat per item with
// the angle and bias estimates held after that item.
// A force item's result can be taken in the cycle after its accepting edge.
// An update item runs the load, 5 prediction steps, the division start,
// one settle state, two gain divisions on one bit-serial divider with a
// capture step for each gain, then 6 correction steps before its result
// can be taken. The next item of either kind can be taken in the cycle
// after the result beat. The divider sets the rate; one item is in flight
// at a time.
// The result is held until taken; a stalled receiver stalls the input.
// Reset clears state and covariance to zero and loads the default noises.
// Configuration writes (i_cfg_we, i_cfg_idx, i_cfg_data) apply at once; the
// user must make them while the core is idle (not enforced); unknown indexes are ignored.
`default_nettype none
module kalman_angle_bias_filter_core import kabf_pkg::*; (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_cfg_we,
    input  wire [CfgIdxW-1:0] i_cfg_idx,
    input  wire [30:0]        i_cfg_data,
    input  wire               i_in_valid,
    output logic              o_in_ready,
    input  wire               i_op,
    input  wire signed [31:0] i_measured_angle,
    input  wire signed [31:0] i_measured_rate,
    input  wire [15:0]        i_elapsed_time,
    output logic              o_out_valid,
    input  wire               i_out_ready,
    output logic signed [31:0] o_angle_estimate,
    output logic signed [31:0] o_bias_estimate
);
    t_cmd    cmd;
    t_status status;

    kabf_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in_valid(i_in_valid),
        .o_in_ready(o_in_ready), .i_op(i_op), .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready), .i_status(status), .o_cmd(cmd)
    );

    kabf_datapath u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd), .o_status(status),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .i_meas(i_measured_angle), .i_rate(i_measured_rate),
        .i_dt(i_elapsed_time), .o_angle(o_angle_estimate), .o_bias(o_bias_estimate)
    );
endmodule
`default_nettype wire

// ===== design/kabf_div.sv =====
// Module: radix-2 restoring signed divider for gain computation.
`default_nettype none
module kabf_div import kabf_pkg::*; (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_start,
    input  wire signed [31:0]   i_num,   // covariance, scaled by 2^28 inside
    input  wire signed [32:0]   i_den,   // innovation variance
    output logic                o_busy,
    output logic signed [31:0]  o_quot
);
    logic [5:0]  r_cnt;
    logic        r_busy;
    logic [59:0] r_q;
    logic [32:0] r_rem;
    logic [32:0] r_d;
    logic        r_neg;
    logic        r_zero;
    logic [33:0] w_trial;
    logic [59:0] w_mag;
    logic signed [61:0] w_sq;

    assign w_trial = {r_rem, r_q[59]} - {1'b0, r_d};

    // step one quotient bit per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= 6'd60;
        end else if (r_busy) begin
            r_cnt <= r_cnt - 6'd1;
            if (r_cnt == 6'd1) r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_neg  <= i_num[31];
            r_zero <= (i_den <= 33'sd0);
            r_d    <= i_den;
            r_rem  <= '0;
            r_q    <= {(i_num[31] ? 32'(-i_num) : 32'(i_num)), 28'd0};
        end else if (r_busy) begin
            if (!w_trial[33]) begin
                r_rem <= w_trial[32:0];
                r_q   <= {r_q[58:0], 1'b1};
            end else begin
                r_rem <= {r_rem[31:0], r_q[59]};
                r_q   <= {r_q[58:0], 1'b0};
            end
        end
    end

    assign w_mag = r_q;
    assign w_sq  = r_neg ? -$signed({2'b00, w_mag}) : $signed({2'b00, w_mag});
    assign o_busy = r_busy;
    assign o_quot = r_zero ? 32'sd0 : sat32(66'(w_sq));
endmodule
`default_nettype wire

// ===== design/kabf_datapath.sv =====
// Module: filter state, multipliers and a shared divider, sequenced by commands.
`default_nettype none
module kabf_datapath import kabf_pkg::*; (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  t_cmd               i_cmd,
    output t_status            o_status,
    input  wire                i_cfg_we,
    input  wire [CfgIdxW-1:0]  i_cfg_idx,
    input  wire [30:0]         i_cfg_data,
    input  wire signed [31:0]  i_meas,
    input  wire signed [31:0]  i_rate,
    input  wire [15:0]         i_dt,
    output logic signed [31:0] o_angle,
    output logic signed [31:0] o_bias
);
    logic [30:0] r_qa, r_qb, r_rm;
    logic signed [31:0] r_ang, r_bias, r_p00, r_p01, r_p10, r_p11;
    logic signed [31:0] r_meas, r_rate, r_dp11, r_inner, r_y, r_k0, r_k1;
    logic signed [31:0] r_a00, r_a01;   // predicted p00, p01 held for correction
    logic [15:0] r_dt;
    logic signed [32:0] w_s;
    logic signed [31:0] w_dq;
    logic div_busy;
    logic div_start;
    logic signed [31:0] div_num;
    logic signed [65:0] w_dtr, w_dtp, w_dti, w_qbt, w_m0, w_m1;

    // one multiply per step
    assign w_dtr = $signed({1'b0, r_dt}) * r_rate;
    assign w_dtp = $signed({1'b0, r_dt}) * r_p11;
    assign w_dti = $signed({1'b0, r_dt}) * r_inner;
    assign w_qbt = $signed({1'b0, r_qb}) * $signed({1'b0, r_dt});
    assign w_m0  = r_k0 * r_y;
    assign w_m1  = r_k1 * r_y;
    logic signed [65:0] w_mc;
    always_comb begin
        case (i_cmd.uop)
            UOP_C00: w_mc = r_k0 * r_a00;
            UOP_C01: w_mc = r_k0 * r_a01;
            UOP_C10: w_mc = r_k1 * r_a00;
            default: w_mc = r_k1 * r_a01;
        endcase
    end

    assign w_s = 33'(r_p00) + $signed({2'b00, r_rm});
    assign div_start = (i_cmd.uop == UOP_DIVS) || (i_cmd.uop == UOP_DIVK0);
    assign div_num = (i_cmd.uop == UOP_DIVS) ? r_p00 : r_p10;

    kabf_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(div_start),
        .i_num(div_num), .i_den(w_s), .o_busy(div_busy), .o_quot(w_dq)
    );

    assign o_status.div_busy = div_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qa <= RST_Q_ANGLE; r_qb <= RST_Q_BIAS; r_rm <= RST_R_MEAS;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_Q_ANGLE: r_qa <= i_cfg_data;
                CFG_Q_BIAS:  r_qb <= i_cfg_data;
                CFG_R_MEAS:  r_rm <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // advance the filter one micro-operation
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ang <= '0; r_bias <= '0;
            r_p00 <= '0; r_p01 <= '0; r_p10 <= '0; r_p11 <= '0;
        end else begin
            case (i_cmd.uop)
                UOP_LOAD: begin
                    r_meas <= i_meas;
                    r_dt   <= i_dt;
                    r_rate <= sat32(66'(i_rate) - 66'(r_bias));
                end
                UOP_FORCE: r_ang <= i_meas;
                UOP_ANG:  r_ang <= sat32(66'(r_ang) + rsh16(w_dtr));
                UOP_DP11: r_dp11 <= sat32(rsh16(w_dtp));
                UOP_INNER: r_inner <= sat32(66'(r_dp11) - 66'(r_p01) - 66'(r_p10)
                                           + $signed({35'd0, r_qa}));
                UOP_P00: r_p00 <= sat32(66'(r_p00) + rsh16(w_dti));
                UOP_P11: begin
                    r_p01 <= sat32(66'(r_p01) - 66'(r_dp11));
                    r_p10 <= sat32(66'(r_p10) - 66'(r_dp11));
                    r_p11 <= sat32(66'(r_p11) + rsh16(w_qbt));
                end
                UOP_DIVS: begin
                    r_y   <= sat32(66'(r_meas) - 66'(r_ang));
                    r_a00 <= r_p00;
                    r_a01 <= r_p01;
                end
                UOP_DIVK0: r_k0 <= w_dq;
                UOP_DIVK1: r_k1 <= w_dq;
                UOP_CA: r_ang  <= sat32(66'(r_ang) + rsh28(w_m0));
                UOP_CB: r_bias <= sat32(66'(r_bias) + rsh28(w_m1));
                UOP_C00: r_p00 <= sat32(66'(r_a00) - rsh28(w_mc));
                UOP_C01: r_p01 <= sat32(66'(r_a01) - rsh28(w_mc));
                UOP_C10: r_p10 <= sat32(66'(r_p10) - rsh28(w_mc));
                UOP_C11: r_p11 <= sat32(66'(r_p11) - rsh28(w_mc));
                default: ;
            endcase
        end
    end

    assign o_angle = r_ang;
    assign o_bias  = r_bias;
endmodule
`default_nettype wire

// ===== design/kabf_ctrl.sv =====
// Module: sequencer that steps the datapath through one filter item.
`default_nettype none
module kabf_ctrl import kabf_pkg::*; (
    input  wire     i_clk,
    input  wire     i_rst_n,
    input  wire     i_in_valid,
    output logic    o_in_ready,
    input  wire     i_op,
    output logic    o_out_valid,
    input  wire     i_out_ready,
    input  t_status i_status,
    output t_cmd    o_cmd
);
    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_PRED = 7'b0000010,
        S_DIV0 = 7'b0000100,
        S_DIV1 = 7'b0001000,
        S_CORR = 7'b0010000,
        S_OUT  = 7'b0100000,
        S_WAIT = 7'b1000000
    } t_state;

    t_state r_state, n_state;
    logic [2:0] r_step, n_step;
    logic w_acc;

    assign o_in_ready = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_OUT);
    assign w_acc = i_in_valid && o_in_ready;

    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        o_cmd.uop = UOP_NONE;
        unique case (r_state)
            S_IDLE: if (w_acc) begin
                if (i_op == OP_FORCE) begin
                    o_cmd.uop = UOP_FORCE; n_state = S_OUT;
                end else begin
                    o_cmd.uop = UOP_LOAD; n_state = S_PRED; n_step = '0;
                end
            end
            S_PRED: begin
                case (r_step)
                    3'd0: o_cmd.uop = UOP_ANG;
                    3'd1: o_cmd.uop = UOP_DP11;
                    3'd2: o_cmd.uop = UOP_INNER;
                    3'd3: o_cmd.uop = UOP_P00;
                    3'd4: o_cmd.uop = UOP_P11;
                    default: o_cmd.uop = UOP_DIVS;
                endcase
                n_step = r_step + 3'd1;
                if (r_step == 3'd5) begin
                    n_state = S_WAIT; n_step = '0;
                end
            end
            S_WAIT: n_state = S_DIV0;
            S_DIV0: if (!i_status.div_busy) begin
                o_cmd.uop = UOP_DIVK0; n_state = S_DIV1;
            end
            S_DIV1: if (!i_status.div_busy) begin
                o_cmd.uop = UOP_DIVK1; n_state = S_CORR; n_step = '0;
            end
            S_CORR: begin
                case (r_step)
                    3'd0: o_cmd.uop = UOP_CA;
                    3'd1: o_cmd.uop = UOP_CB;
                    3'd2: o_cmd.uop = UOP_C00;
                    3'd3: o_cmd.uop = UOP_C01;
                    3'd4: o_cmd.uop = UOP_C10;
                    default: o_cmd.uop = UOP_C11;
                endcase
                n_step = r_step + 3'd1;
                if (r_step == 3'd5) n_state = S_OUT;
            end
            S_OUT: if (i_out_ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !o_in_ready) else $error("ready while busy");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> o_out_valid) else $error("result dropped");
    a_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_state)) else $error("state not one-hot");
endmodule
`default_nettype wire

// ===== bench/tb_kalman_angle_bias_filter_core.sv =====
// Testbench for the angle and gyro-bias Kalman filter core: directed and random beats.
module tb_kalman_angle_bias_filter_core import kabf_pkg::*; ();
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic signed [31:0] angle;
        logic signed [31:0] bias;
    } t_estimate;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_cfg_we = 1'b0;
    logic [CfgIdxW-1:0] i_cfg_idx = '0;
    logic [30:0]        i_cfg_data = '0;
    logic               i_in_valid = 1'b0;
    logic               o_in_ready;
    logic               i_op = OP_UPDATE;
    logic signed [31:0] i_measured_angle = '0;
    logic signed [31:0] i_measured_rate = '0;
    logic [15:0]        i_elapsed_time = '0;
    logic               o_out_valid;
    logic               i_out_ready = 1'b0;
    logic signed [31:0] o_angle_estimate;
    logic signed [31:0] o_bias_estimate;

    kalman_angle_bias_filter_core DUT (.*);

    // filter model state
    longint q_angle, q_bias, r_meas;
    longint est_angle, est_bias, p_aa, p_ab, p_ba, p_bb;
    t_estimate pending_estimates[$];
    int  errors = 0;
    int  send_idle_pct = 0;
    int  recv_idle_pct = 0;
    longint cycles = 0;
    localparam longint CycleLimit = 64'd3_000_000;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic longint clamp32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    // round half up, then floor shift
    function automatic longint round_shift(longint v, int n);
        return (v + (64'sd1 <<< (n - 1))) >>> n;
    endfunction

    function automatic longint gain_of(longint c, longint s);
        if (s <= 0) return 0;
        return clamp32((c * (64'sd1 <<< 28)) / s);
    endfunction

    task automatic model_reset();
        q_angle = RST_Q_ANGLE; q_bias = RST_Q_BIAS; r_meas = RST_R_MEAS;
        est_angle = 0; est_bias = 0; p_aa = 0; p_ab = 0; p_ba = 0; p_bb = 0;
    endtask

    task automatic predict_estimate(logic op, logic signed [31:0] meas,
                                    logic signed [31:0] rate_in, logic [15:0] dt_in);
        longint dt, rate, dp11, inner, p00, p01, p10, p11, s, k0, k1, y;
        t_estimate e;
        dt = dt_in;
        if (op == OP_FORCE) begin
            est_angle = meas;
        end else begin
            rate = clamp32(longint'(rate_in) - est_bias);
            est_angle = clamp32(est_angle + round_shift(dt * rate, 16));
            dp11 = round_shift(dt * p_bb, 16);
            inner = clamp32(dp11 - p_ab - p_ba + q_angle);
            p00 = clamp32(p_aa + round_shift(dt * inner, 16));
            p01 = clamp32(p_ab - dp11);
            p10 = clamp32(p_ba - dp11);
            p11 = clamp32(p_bb + round_shift(q_bias * dt, 16));
            s = p00 + r_meas;
            k0 = gain_of(p00, s);
            k1 = gain_of(p10, s);
            y = clamp32(longint'(meas) - est_angle);
            est_angle = clamp32(est_angle + round_shift(k0 * y, 28));
            est_bias = clamp32(est_bias + round_shift(k1 * y, 28));
            p_aa = clamp32(p00 - round_shift(k0 * p00, 28));
            p_ab = clamp32(p01 - round_shift(k0 * p01, 28));
            p_ba = clamp32(p10 - round_shift(k1 * p00, 28));
            p_bb = clamp32(p11 - round_shift(k1 * p01, 28));
        end
        e.angle = est_angle[31:0];
        e.bias = est_bias[31:0];
        pending_estimates.push_back(e);
    endtask

    // send one item beat, optionally idling first; valid stays up after accept
    task automatic send_item(logic op, logic signed [31:0] meas,
                             logic signed [31:0] rate, logic [15:0] dt);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_op <= op;
        i_measured_angle <= meas;
        i_measured_rate <= rate;
        i_elapsed_time <= dt;
        predict_estimate(op, meas, rate, dt);
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (pending_estimates.size() != 0) @(posedge i_clk);
        repeat (150) @(posedge i_clk);
    endtask

    // write a register while idle
    task automatic write_cfg(logic [CfgIdxW-1:0] idx, logic [30:0] val);
        i_cfg_we <= 1'b1; i_cfg_idx <= idx; i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_Q_ANGLE) q_angle = val;
        else if (idx == CFG_Q_BIAS) q_bias = val;
        else if (idx == CFG_R_MEAS) r_meas = val;
    endtask

    // receiver stall and result check
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
            if (o_out_valid && i_out_ready) begin
                if (pending_estimates.size() == 0) begin
                    $error("unexpected result beat angle=%0d bias=%0d",
                           o_angle_estimate, o_bias_estimate);
                    errors++;
                end else begin
                    t_estimate e;
                    e = pending_estimates.pop_front();
                    if (o_angle_estimate !== e.angle) begin
                        $error("angle_estimate expected %0d actual %0d",
                               e.angle, o_angle_estimate);
                        errors++;
                    end
                    if (o_bias_estimate !== e.bias) begin
                        $error("bias_estimate expected %0d actual %0d",
                               e.bias, o_bias_estimate);
                        errors++;
                    end
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CycleLimit) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    function automatic logic [31:0] rand_word();
        case ($urandom_range(3))
            0: return $urandom();
            1: return $urandom_range(32'h0028_0000);
            2: return -$urandom_range(32'h0028_0000);
            default: return {$urandom_range(1) ? 32'h8000_0000 : 32'h7fff_ffff};
        endcase
    endfunction

    task automatic test_directed_extremes();
        send_item(OP_UPDATE, 32'sd0, 32'sd0, 16'd0);
        send_item(OP_UPDATE, 32'sh0001_0000, 32'sh0000_8000, 16'd655);
        send_item(OP_FORCE, 32'sh7fff_ffff, 32'sd0, 16'hffff);
        send_item(OP_UPDATE, 32'sh8000_0000, 32'sh7fff_ffff, 16'hffff);
        send_item(OP_UPDATE, 32'sh7fff_ffff, 32'sh8000_0000, 16'hffff);
        send_item(OP_FORCE, 32'sh8000_0000, 32'sh7fff_ffff, 16'd0);
        send_item(OP_UPDATE, 32'shffff_ffff, 32'shffff_ffff, 16'h8000);
        send_item(OP_UPDATE, 32'sh5555_5555, 32'shaaaa_aaaa, 16'h5555);
        send_item(OP_UPDATE, 32'shaaaa_aaaa, 32'sh5555_5555, 16'haaaa);
        send_item(OP_FORCE, 32'sd0, 32'sd0, 16'd1);
        wait_drained();
    endtask

    task automatic test_config_extremes();
        // zero measurement noise and zero process noise
        write_cfg(CFG_R_MEAS, 31'd0);
        write_cfg(CFG_Q_ANGLE, 31'd0);
        write_cfg(CFG_Q_BIAS, 31'd0);
        write_cfg(2'd3, 31'h7fff_ffff); // unknown index, dropped
        repeat (4) send_item(OP_UPDATE, rand_word(), rand_word(), 16'd655);
        wait_drained();
        write_cfg(CFG_R_MEAS, 31'h7fff_ffff);
        write_cfg(CFG_Q_ANGLE, 31'h7fff_ffff);
        write_cfg(CFG_Q_BIAS, 31'h7fff_ffff);
        repeat (6) send_item(OP_UPDATE, rand_word(), rand_word(), 16'hffff);
        send_item(OP_FORCE, 32'sd0, 32'sd0, 16'd0);
        wait_drained();
    endtask

    task automatic run_random(int n);
        for (int i = 0; i < n; i++) begin
            logic op;
            logic [15:0] dt;
            op = ($urandom_range(9) == 0) ? OP_FORCE : OP_UPDATE;
            dt = ($urandom_range(7) == 0) ? 16'($urandom()) : 16'($urandom_range(2000));
            send_item(op, rand_word(), rand_word(), dt);
        end
        wait_drained();
    endtask

    task automatic test_random_phases();
        write_cfg(CFG_Q_ANGLE, RST_Q_ANGLE);
        write_cfg(CFG_Q_BIAS, RST_Q_BIAS);
        write_cfg(CFG_R_MEAS, RST_R_MEAS);
        send_idle_pct = 9; recv_idle_pct = 67;
        run_random(280);
        write_cfg(CFG_Q_ANGLE, 31'($urandom()));
        write_cfg(CFG_Q_BIAS, 31'($urandom_range(1 << 24)));
        write_cfg(CFG_R_MEAS, 31'($urandom_range(1, 1 << 28)));
        send_idle_pct = 67; recv_idle_pct = 9;
        run_random(280);
        write_cfg(CFG_Q_ANGLE, 31'd1);
        write_cfg(CFG_Q_BIAS, 31'd1);
        write_cfg(CFG_R_MEAS, 31'd1);
        send_idle_pct = 0; recv_idle_pct = 0;
        run_random(270);
    endtask

    initial begin
        model_reset();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed_extremes();
        test_config_extremes();
        test_random_phases();
        if (errors == 0 && pending_estimates.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule
